// File: design/sequence_reorder_buffer_macros.svh
// Assertion macros for the sequence reorder buffer.
// Included by the top level; no other dependencies.
`ifndef SEQUENCE_REORDER_BUFFER_MACROS_SVH
`define SEQUENCE_REORDER_BUFFER_MACROS_SVH

`ifndef ASSERT_OFF

`define SRB_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("sequence_reorder_buffer: assertion failed");

`define SRB_ASSERT_NEVER(label, clk, rst, cond) \
   `SRB_ASSERT(label, clk, rst, !(cond))

`else

`define SRB_ASSERT(label, clk, rst, prop)

`define SRB_ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// File: design/srb_pkg.sv
// Shared types and constants of the sequence reorder buffer.
// No dependencies; used by the channel interfaces, the slot cell and the top level.
package srb_pkg;

   localparam int SEQ_W         = 32;
   localparam int TYPE_W        = 16;
   localparam int TAG_W         = 16;
   localparam int SLOTS_DEFAULT = 63;

   localparam logic [SEQ_W-1:0] START_SEQ_RESET = 32'd1;
   localparam logic [SEQ_W-1:0] SEQ_UNSEQUENCED = 32'd0;

   localparam logic STATUS_RELEASED = 1'b0;
   localparam logic STATUS_DROPPED  = 1'b1;

   typedef struct packed {
      logic [SEQ_W-1:0]  seq_num;
      logic [TYPE_W-1:0] type_id;
      logic [TAG_W-1:0]  tag;
   } pkt_type;

   // Command broadcast from the controller to every slot cell.
   typedef struct packed {
      logic    wr_en;
      logic    clr_en;
      pkt_type wr_data;
   } cell_ctrl_type;

   // Signals handed from one cell to the next, lowest index first.
   typedef struct packed {
      logic    match_seen;
      logic    free_seen;
      pkt_type data;
   } cell_chain_type;

   typedef struct packed {
      logic wr_hit;
      logic clr_hit;
   } cell_hit_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ARRIVE,
      ST_DRAIN
   } state_type;

endpackage

// File: design/srb_channels.sv
// Valid/ready channel interfaces for the packet input and result output.
// Depends on srb_pkg for field widths.
interface srb_req_if;
   logic                         valid;
   logic                         ready;
   logic [srb_pkg::SEQ_W-1:0]    sequence_req;
   logic [srb_pkg::TYPE_W-1:0]   type_id;
   logic [srb_pkg::TAG_W-1:0]    package_tag;

   modport source (output valid, output sequence_req, output type_id, output package_tag,
                   input ready);
   modport sink (input valid, input sequence_req, input type_id, input package_tag,
                 output ready);
endinterface

interface srb_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [srb_pkg::TAG_W-1:0]    out_tag;
   logic [srb_pkg::TYPE_W-1:0]   out_type;
   logic [srb_pkg::SEQ_W-1:0]    out_sequence;
   logic                         status;
   logic                         last;

   modport source (output valid, output out_tag, output out_type, output out_sequence,
                   output status, output last, input ready);
   modport sink (input valid, input out_tag, input out_type, input out_sequence,
                 input status, input last, output ready);
endinterface

// File: design/srb_cell.sv
// One slot of the reorder store: holds a parked packet and compares it to the expected sequence.
// Depends on srb_pkg; instantiated in a chain by sequence_reorder_buffer.
module srb_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [srb_pkg::SEQ_W-1:0]  expected,
   input  srb_pkg::cell_ctrl_type     ctrl,
   input  srb_pkg::cell_chain_type    chain_in,
   output srb_pkg::cell_chain_type    chain_out,
   output srb_pkg::cell_hit_type      hit
);

   logic             valid_ff;
   logic             valid_in;
   srb_pkg::pkt_type data_ff;
   logic             match;
   logic             free;
   logic             grant;

   assign match = valid_ff && (data_ff.seq_num == expected);
   assign free  = !valid_ff;
   // Only the lowest matching cell is granted; the chain carries whether a lower one matched.
   assign grant = match && !chain_in.match_seen;

   assign hit.wr_hit  = ctrl.wr_en && free && !chain_in.free_seen;
   assign hit.clr_hit = ctrl.clr_en && grant;

   assign chain_out.match_seen = chain_in.match_seen || match;
   assign chain_out.free_seen  = chain_in.free_seen || free;
   assign chain_out.data       = srb_pkg::pkt_type'(chain_in.data | (grant ? data_ff : '0));

   always_comb begin
      valid_in = valid_ff;
      if (hit.wr_hit) begin
         valid_in = 1'b1;
      end else if (hit.clr_hit) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hit.wr_hit) begin
         data_ff <= ctrl.wr_data;
      end
   end

endmodule

// File: design/sequence_reorder_buffer.sv
// Sequence reorder buffer: accepts packets tagged with a sequence number and releases them in
// order. A packet matching the expected sequence (or carrying sequence zero) is released at
// once; others park in the lowest free of SLOTS cells, or come back with status dropped when
// all cells are full. After each arrival, parked packets are drained one per cycle while the
// result port is not stalled, the lowest matching cell first. An input transaction runs through
// accept, the arrival decision, one step per release and a final no-match check; a stalled
// result port holds the drain steps back.
// Results for one input leave in order with last set on the final one. The csr write loads
// the expected sequence and is meant for idle periods only.
`include "sequence_reorder_buffer_macros.svh"

module sequence_reorder_buffer #(
   parameter int SLOTS = srb_pkg::SLOTS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   srb_req_if.sink                    req_chan,
   srb_rsp_if.source                  rsp_chan,
   input  logic                       csr_write,
   input  logic [srb_pkg::SEQ_W-1:0]  csr_wdata
);

   srb_pkg::state_type   state_ff;
   srb_pkg::state_type   state_in;

   srb_pkg::pkt_type     item_ff;
   logic [srb_pkg::SEQ_W-1:0] expected_ff;
   logic [srb_pkg::SEQ_W-1:0] expected_in;

   logic                 hold_valid_ff;
   logic                 hold_valid_in;
   srb_pkg::pkt_type     hold_ff;
   srb_pkg::pkt_type     hold_in;
   logic                 hold_status_ff;
   logic                 hold_status_in;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   srb_pkg::pkt_type     rsp_data_ff;
   logic                 rsp_status_ff;
   logic                 rsp_last_ff;

   srb_pkg::cell_ctrl_type  cell_ctrl;
   srb_pkg::cell_chain_type chain [SLOTS+1];
   logic [SLOTS-1:0]        wr_hit_vec;
   logic [SLOTS-1:0]        clr_hit_vec;

   logic any_match;
   logic any_free;
   logic out_free;
   logic release_now;
   logic accept;
   logic emit;
   logic emit_last;

   // Slot cell chain.
   assign chain[0] = '0;

   genvar gi;
   generate
      for (gi = 0; gi < SLOTS; gi++) begin : g_cell
         srb_pkg::cell_hit_type hit;

         srb_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .expected  (expected_ff),
            .ctrl      (cell_ctrl),
            .chain_in  (chain[gi]),
            .chain_out (chain[gi+1]),
            .hit       (hit)
         );

         assign wr_hit_vec[gi]  = hit.wr_hit;
         assign clr_hit_vec[gi] = hit.clr_hit;
      end
   endgenerate

   assign any_match = chain[SLOTS].match_seen;
   assign any_free  = chain[SLOTS].free_seen;

   assign out_free    = !rsp_valid_ff || rsp_chan.ready;
   assign release_now = (item_ff.seq_num == expected_ff) ||
                        (item_ff.seq_num == srb_pkg::SEQ_UNSEQUENCED);
   assign accept      = req_chan.valid && req_chan.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srb_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = srb_pkg::ST_ARRIVE;
            end
         end
         srb_pkg::ST_ARRIVE: begin
            state_in = srb_pkg::ST_DRAIN;
         end
         srb_pkg::ST_DRAIN: begin
            if (!any_match && (!hold_valid_ff || out_free)) begin
               state_in = srb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = srb_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath control. The held result waits until the next drain check decides its last flag.
   always_comb begin
      cell_ctrl.wr_en   = 1'b0;
      cell_ctrl.clr_en  = 1'b0;
      cell_ctrl.wr_data = item_ff;
      expected_in       = expected_ff;
      hold_valid_in     = hold_valid_ff;
      hold_in           = hold_ff;
      hold_status_in    = hold_status_ff;
      emit              = 1'b0;
      emit_last         = 1'b0;
      case (state_ff)
         srb_pkg::ST_IDLE: begin
         end
         srb_pkg::ST_ARRIVE: begin
            if (release_now) begin
               hold_valid_in  = 1'b1;
               hold_in        = item_ff;
               hold_status_in = srb_pkg::STATUS_RELEASED;
               if (item_ff.seq_num != srb_pkg::SEQ_UNSEQUENCED) begin
                  expected_in = expected_ff + 32'd1;
               end
            end else if (any_free) begin
               cell_ctrl.wr_en = 1'b1;
            end else begin
               hold_valid_in  = 1'b1;
               hold_in        = item_ff;
               hold_status_in = srb_pkg::STATUS_DROPPED;
            end
         end
         srb_pkg::ST_DRAIN: begin
            if (any_match) begin
               if (!hold_valid_ff || out_free) begin
                  emit             = hold_valid_ff;
                  cell_ctrl.clr_en = 1'b1;
                  hold_valid_in    = 1'b1;
                  hold_in          = chain[SLOTS].data;
                  hold_status_in   = srb_pkg::STATUS_RELEASED;
                  expected_in      = expected_ff + 32'd1;
               end
            end else if (hold_valid_ff && out_free) begin
               emit          = 1'b1;
               emit_last     = 1'b1;
               hold_valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
      if (csr_write) begin
         expected_in = csr_wdata;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= srb_pkg::ST_IDLE;
         expected_ff   <= srb_pkg::START_SEQ_RESET;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         expected_ff   <= expected_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.seq_num <= req_chan.sequence_req;
         item_ff.type_id <= req_chan.type_id;
         item_ff.tag     <= req_chan.package_tag;
      end
      hold_ff        <= hold_in;
      hold_status_ff <= hold_status_in;
      if (emit) begin
         rsp_data_ff   <= hold_ff;
         rsp_status_ff <= hold_status_ff;
         rsp_last_ff   <= emit_last;
      end
   end

   assign req_chan.ready        = (state_ff == srb_pkg::ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.out_tag      = rsp_data_ff.tag;
   assign rsp_chan.out_type     = rsp_data_ff.type_id;
   assign rsp_chan.out_sequence = rsp_data_ff.seq_num;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.last         = rsp_last_ff;

   // Checks.
   `SRB_ASSERT(a_single_write, clock, reset, $onehot0(wr_hit_vec))
   `SRB_ASSERT(a_single_clear, clock, reset, $onehot0(clr_hit_vec))
   `SRB_ASSERT_NEVER(a_idle_no_hold, clock, reset, (state_ff == srb_pkg::ST_IDLE) && hold_valid_ff)
   `SRB_ASSERT(a_write_only_arrive, clock, reset,
      (wr_hit_vec != '0) |-> (state_ff == srb_pkg::ST_ARRIVE) && !release_now)

endmodule

// File: bench/tb.sv
// Self-checking testbench for the sequence reorder buffer.
// Depends on srb_pkg, the channel interfaces in srb_channels.sv and the top level.
`timescale 1ns / 1ps

module tb;

   localparam int SLOTS       = srb_pkg::SLOTS_DEFAULT;
   localparam int STALL_LIMIT = 2000;
   localparam int CSR_SETTLE  = 10;
   localparam int END_SETTLE  = 80;
   localparam int DIR_ROWS    = 20;

   typedef enum logic {ROW_PKT, ROW_CSR} row_kind_type;

   // How a directed row is checked: by the predictor, by a result typed into the row, or as held with no result.
   typedef enum logic [1:0] {EXP_PREDICT, EXP_HELD, EXP_RELEASED} exp_form_type;

   typedef struct packed {
      row_kind_type                 kind;
      exp_form_type                 form;
      logic [srb_pkg::SEQ_W-1:0]    seq;
      logic [srb_pkg::TYPE_W-1:0]   tid;
      logic [srb_pkg::TAG_W-1:0]    tag;
   } dir_row_type;

   typedef struct packed {
      logic [srb_pkg::TAG_W-1:0]    tag;
      logic [srb_pkg::TYPE_W-1:0]   tid;
      logic [srb_pkg::SEQ_W-1:0]    seq;
      logic                         status;
      logic                         last;
   } rel_rec_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_write;
   logic [srb_pkg::SEQ_W-1:0] csr_wdata;

   srb_req_if req_bus ();
   srb_rsp_if rsp_bus ();

   sequence_reorder_buffer #(
      .SLOTS(SLOTS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Predictor state: next sequence to release and the parked packets.
   logic [srb_pkg::SEQ_W-1:0] want_seq = srb_pkg::START_SEQ_RESET;
   logic                      park_valid [SLOTS];
   srb_pkg::pkt_type          park_pkt [SLOTS];

   rel_rec_type step_q[$];
   rel_rec_type release_q[$];
   rel_rec_type head;

   dir_row_type dir_rows [DIR_ROWS];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int pkt_count      = 0;
   int mismatches     = 0;
   int idle_cycles    = 0;

   function automatic logic [15:0] rand16();
      return 16'($urandom_range(16'hFFFF, 0));
   endfunction

   function automatic rel_rec_type make_rec(input srb_pkg::pkt_type pkt, input logic status);
      rel_rec_type rec;
      rec.tag    = pkt.tag;
      rec.tid    = pkt.type_id;
      rec.seq    = pkt.seq_num;
      rec.status = status;
      rec.last   = 1'b0;
      return rec;
   endfunction

   // Works out the results of one arriving packet into step_q.
   function automatic void reorder_step(input srb_pkg::pkt_type pkt);
      int i;
      int slot;
      step_q.delete();
      if (pkt.seq_num == want_seq || pkt.seq_num == srb_pkg::SEQ_UNSEQUENCED) begin
         step_q.insert(step_q.size(), make_rec(pkt, srb_pkg::STATUS_RELEASED));
         if (pkt.seq_num != srb_pkg::SEQ_UNSEQUENCED) begin
            want_seq = want_seq + 32'd1;
         end
      end else begin
         slot = -1;
         for (i = 0; i < SLOTS; i++) begin
            if (!park_valid[i] && slot < 0) begin
               slot = i;
            end
         end
         if (slot < 0) begin
            step_q.insert(step_q.size(), make_rec(pkt, srb_pkg::STATUS_DROPPED));
         end else begin
            park_valid[slot] = 1'b1;
            park_pkt[slot]   = pkt;
         end
      end
      do begin
         slot = -1;
         for (i = 0; i < SLOTS; i++) begin
            if (park_valid[i] && park_pkt[i].seq_num == want_seq && slot < 0) begin
               slot = i;
            end
         end
         if (slot >= 0) begin
            step_q.insert(step_q.size(), make_rec(park_pkt[slot], srb_pkg::STATUS_RELEASED));
            park_valid[slot] = 1'b0;
            want_seq = want_seq + 32'd1;
         end
      end while (slot >= 0);
      if (step_q.size() > 0) begin
         step_q[step_q.size() - 1].last = 1'b1;
      end
   endfunction

   task flag_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic send_packet(input logic [srb_pkg::SEQ_W-1:0] seq,
                              input logic [srb_pkg::TYPE_W-1:0] tid,
                              input logic [srb_pkg::TAG_W-1:0] tag, input exp_form_type form);
      srb_pkg::pkt_type pkt;
      rel_rec_type      rec;
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_bus.valid        <= 1'b1;
      req_bus.sequence_req <= seq;
      req_bus.type_id      <= tid;
      req_bus.package_tag  <= tag;
      do @(posedge clock); while (!req_bus.ready);
      pkt.seq_num = seq;
      pkt.type_id = tid;
      pkt.tag     = tag;
      reorder_step(pkt);
      if (form == EXP_PREDICT) begin
         while (step_q.size() > 0) begin
            release_q.insert(release_q.size(), step_q.pop_front());
         end
      end else if (form == EXP_RELEASED) begin
         rec = make_rec(pkt, srb_pkg::STATUS_RELEASED);
         rec.last = 1'b1;
         release_q.insert(release_q.size(), rec);
      end
      pkt_count++;
   endtask

   task automatic wait_for_quiet(input int extra);
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (release_q.size() != 0);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_start(input logic [srb_pkg::SEQ_W-1:0] value);
      csr_write <= 1'b1;
      csr_wdata <= value;
      want_seq = value;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Sends sequences want_seq .. want_seq+n-1 in shuffled order, with some noise mixed in.
   task automatic send_window(input int n);
      logic [srb_pkg::SEQ_W-1:0] win [16];
      logic [srb_pkg::SEQ_W-1:0] tmp;
      int                        j;
      int                        k;
      int                        r;
      for (j = 0; j < n; j++) begin
         win[j] = want_seq + j;
      end
      for (j = n - 1; j > 0; j--) begin
         k      = $urandom_range(j, 0);
         tmp    = win[j];
         win[j] = win[k];
         win[k] = tmp;
      end
      for (j = 0; j < n; j++) begin
         if ($urandom_range(99) < 15) begin
            r = $urandom_range(99);
            if (r < 70) begin
               tmp = srb_pkg::SEQ_UNSEQUENCED;
            end else if (r < 85) begin
               tmp = win[$urandom_range(j, 0)];
            end else begin
               tmp = $urandom;
            end
            send_packet(tmp, rand16(), rand16(), EXP_PREDICT);
         end
         send_packet(win[j], rand16(), rand16(), EXP_PREDICT);
      end
   endtask

   task automatic run_windows(input int target);
      while (pkt_count < target) begin
         if (want_seq == srb_pkg::SEQ_UNSEQUENCED || want_seq > 32'hFFFF_FF00) begin
            wait_for_quiet(CSR_SETTLE);
            write_start($urandom_range(32'hFFFF_0000, 2));
         end
         send_window($urandom_range(12, 1));
         if ($urandom_range(9) == 0) begin
            wait_for_quiet(0);
         end
      end
   endtask

   // Empties the store, fills it exactly, overflows it, then releases all of it at once.
   task automatic run_flood();
      logic [srb_pkg::SEQ_W-1:0] base;
      logic [srb_pkg::SEQ_W-1:0] order [SLOTS];
      logic [srb_pkg::SEQ_W-1:0] tmp;
      int                        slot;
      int                        j;
      int                        k;
      slot = 0;
      while (slot < SLOTS) begin
         if (park_valid[slot]) begin
            // Point the expected sequence at a parked packet and let an unsequenced one drain it.
            wait_for_quiet(CSR_SETTLE);
            write_start(park_pkt[slot].seq_num);
            send_packet(srb_pkg::SEQ_UNSEQUENCED, rand16(), rand16(), EXP_PREDICT);
            slot = 0;
         end else begin
            slot++;
         end
      end
      wait_for_quiet(CSR_SETTLE);
      write_start($urandom_range(32'hFFFF_0000, 2));
      base = want_seq;
      for (j = 0; j < SLOTS; j++) begin
         order[j] = base + 1 + j;
      end
      for (j = SLOTS - 1; j > 0; j--) begin
         k        = $urandom_range(j, 0);
         tmp      = order[j];
         order[j] = order[k];
         order[k] = tmp;
      end
      for (j = 0; j < SLOTS; j++) begin
         send_packet(order[j], rand16(), rand16(), EXP_PREDICT);
      end
      for (j = 0; j < 5; j++) begin
         send_packet(base + SLOTS + 1 + j, rand16(), rand16(), EXP_PREDICT);
      end
      wait_for_quiet(0);
      send_packet(base, rand16(), rand16(), EXP_PREDICT);
      for (j = 0; j < 5; j++) begin
         send_packet(base + SLOTS + 1 + j, rand16(), rand16(), EXP_PREDICT);
      end
   endtask

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (release_q.size() == 0) begin
            flag_mismatch("unexpected result, out_sequence", 64'(rsp_bus.out_sequence), '0);
         end else begin
            head = release_q.pop_front();
            if (rsp_bus.out_tag !== head.tag) begin
               flag_mismatch("out_tag", 64'(rsp_bus.out_tag), 64'(head.tag));
            end
            if (rsp_bus.out_type !== head.tid) begin
               flag_mismatch("out_type", 64'(rsp_bus.out_type), 64'(head.tid));
            end
            if (rsp_bus.out_sequence !== head.seq) begin
               flag_mismatch("out_sequence", 64'(rsp_bus.out_sequence), 64'(head.seq));
            end
            if (rsp_bus.status !== head.status) begin
               flag_mismatch("status", 64'(rsp_bus.status), 64'(head.status));
            end
            if (rsp_bus.last !== head.last) begin
               flag_mismatch("last", 64'(rsp_bus.last), 64'(head.last));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int r;
      reset                = 1'b1;
      csr_write            = 1'b0;
      csr_wdata            = '0;
      req_bus.valid        = 1'b0;
      req_bus.sequence_req = '0;
      req_bus.type_id      = '0;
      req_bus.package_tag  = '0;
      for (r = 0; r < SLOTS; r++) begin
         park_valid[r] = 1'b0;
         park_pkt[r]   = '0;
      end

      dir_rows[0]  = '{ROW_PKT, EXP_RELEASED, 32'h0000_0001, 16'h0000, 16'h0000};
      dir_rows[1]  = '{ROW_PKT, EXP_RELEASED, 32'h0000_0000, 16'hFFFF, 16'hFFFF};
      dir_rows[2]  = '{ROW_PKT, EXP_HELD,     32'h0000_0004, 16'h1234, 16'h0001};
      dir_rows[3]  = '{ROW_PKT, EXP_HELD,     32'h0000_0003, 16'h2345, 16'h0002};
      dir_rows[4]  = '{ROW_PKT, EXP_HELD,     32'h0000_0003, 16'h3456, 16'h0003};
      dir_rows[5]  = '{ROW_PKT, EXP_PREDICT,  32'h0000_0002, 16'h4567, 16'h0004};
      dir_rows[6]  = '{ROW_PKT, EXP_HELD,     32'hFFFF_FFFF, 16'hFFFF, 16'h0000};
      dir_rows[7]  = '{ROW_PKT, EXP_HELD,     32'h8000_0000, 16'h0000, 16'hFFFF};
      dir_rows[8]  = '{ROW_CSR, EXP_PREDICT,  32'hFFFF_FFFF, 16'h0000, 16'h0000};
      dir_rows[9]  = '{ROW_PKT, EXP_PREDICT,  32'h0000_0000, 16'h5678, 16'h0005};
      dir_rows[10] = '{ROW_PKT, EXP_RELEASED, 32'h0000_0000, 16'h6789, 16'h0006};
      dir_rows[11] = '{ROW_PKT, EXP_HELD,     32'h0000_0001, 16'h789A, 16'h0007};
      dir_rows[12] = '{ROW_CSR, EXP_PREDICT,  32'h0000_0001, 16'h0000, 16'h0000};
      dir_rows[13] = '{ROW_PKT, EXP_PREDICT,  32'h0000_0000, 16'h89AB, 16'h0008};
      dir_rows[14] = '{ROW_PKT, EXP_PREDICT,  32'h0000_0002, 16'h9ABC, 16'h0009};
      dir_rows[15] = '{ROW_CSR, EXP_PREDICT,  32'h7FFF_FFFF, 16'h0000, 16'h0000};
      dir_rows[16] = '{ROW_PKT, EXP_PREDICT,  32'h7FFF_FFFF, 16'hA5A5, 16'h5A5A};
      dir_rows[17] = '{ROW_CSR, EXP_PREDICT,  32'h0000_0000, 16'h0000, 16'h0000};
      dir_rows[18] = '{ROW_PKT, EXP_HELD,     32'h0000_0005, 16'h0000, 16'h0000};
      dir_rows[19] = '{ROW_PKT, EXP_RELEASED, 32'h0000_0000, 16'hFFFF, 16'hFFFF};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (r = 0; r < DIR_ROWS; r++) begin
         if (dir_rows[r].kind == ROW_CSR) begin
            wait_for_quiet(CSR_SETTLE);
            write_start(dir_rows[r].seq);
         end else begin
            send_packet(dir_rows[r].seq, dir_rows[r].tid, dir_rows[r].tag, dir_rows[r].form);
         end
      end

      wait_for_quiet(CSR_SETTLE);
      send_idle_pct  = 66;
      recv_stall_pct = 0;
      write_start($urandom_range(32'hFFFF_0000, 2));
      run_windows(pkt_count + 40);

      // The window ends on the largest sequence, so the expected value wraps to zero.
      wait_for_quiet(CSR_SETTLE);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_start(32'hFFFF_FFF8);
      send_window(8);
      run_windows(pkt_count + 30);

      send_idle_pct  = 0;
      recv_stall_pct = 66;
      run_flood();

      wait_for_quiet(CSR_SETTLE);
      send_idle_pct  = 27;
      recv_stall_pct = 27;
      write_start(srb_pkg::START_SEQ_RESET);
      run_windows(pkt_count + 50);

      wait_for_quiet(END_SETTLE);
      if (mismatches == 0 && release_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
